// ===== rtl/core/sal_pkg.sv =====
// Shared types, status codes and helpers for the set-associative tag store.
// No dependencies; imported by every module of the block.
package sal_pkg;

    // Default geometry
    localparam int DEF_WAYS       = 4;
    localparam int DEF_SET_COUNT  = 64;
    localparam int DEF_LINE_BYTES = 64;
    localparam int DEF_MSHR_DEPTH = 16;
    localparam int DEF_ADDR_BITS  = 32;

    // Fixed field widths of the stream words
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISS_DUP   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FILL_EMPTY = 3'd5;

    // Action codes
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_FILL   = 1'b1;

    // One classified word between front and back
    typedef struct packed {
        logic              is_fill;
        logic              is_store;
        logic [ADDR_W-1:0] addr;
    } item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    // Floor of log2 (elaboration only)
    function automatic int flog2(input int v);
        int n;
        int x;
        n = 0;
        x = v;
        while (x > 1) begin
            x = x >> 1;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/sal_front.sv =====
// Front end: accepts request and fill words, masks and classifies them, and
// queues them in a two-entry buffer for the back end. Depends on sal_pkg.
module sal_front
    import sal_pkg::*;
#(
    parameter int ADDR_BITS = DEF_ADDR_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [ADDR_W-1:0] s_tdata,   // addr
    input  logic [1:0]        s_tuser,   // action, is_store
    output queue_head_t       head,
    input  logic              pop
);

    localparam int AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] AMASK = {ADDR_W{1'b1}} >> (ADDR_W - AW);

    item_t      buf_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    item_t      in_item;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;

    // Classify the incoming word
    always_comb
    begin
        in_item.is_fill  = (s_tuser[0] == ACT_FILL);
        in_item.is_store = s_tuser[1];
        in_item.addr     = s_tdata & AMASK;
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = buf_reg[rd_ptr_reg];

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/core/sal_back.sv =====
// Back end: tag row memory with true LRU order, miss buffer, fill release
// sequencer and the output register. Depends on sal_pkg.
module sal_back
    import sal_pkg::*;
#(
    parameter int WAYS       = DEF_WAYS,
    parameter int SET_COUNT  = DEF_SET_COUNT,
    parameter int LINE_BYTES = DEF_LINE_BYTES,
    parameter int MSHR_DEPTH = DEF_MSHR_DEPTH,
    parameter int ADDR_BITS  = DEF_ADDR_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  queue_head_t         head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [ADDR_W-1:0]   m_tdata,
    output logic [STATUS_W-1:0] m_tuser,
    output logic                m_tlast
);

    localparam int AW     = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int OFF    = flog2(LINE_BYTES);
    localparam int IDX    = flog2(SET_COUNT);
    localparam int ROWS   = 1 << IDX;
    localparam int SET_AW = (IDX > 0) ? IDX : 1;
    localparam int TAG_W  = (AW > OFF + IDX) ? (AW - OFF - IDX) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W  = $clog2(MSHR_DEPTH + 1);
    localparam int MI_W   = (MSHR_DEPTH > 1) ? $clog2(MSHR_DEPTH) : 1;
    localparam logic [ADDR_W-1:0] SMASK = ADDR_W'((64'd1 << IDX) - 64'd1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;
    localparam logic [1:0] S_REL   = 2'd3;

    typedef logic [WAYS-1:0][TAG_W-1:0] tags_t;
    typedef logic [WAYS-1:0]            valid_t;
    typedef logic [WAYS-1:0][WAY_W-1:0] lru_t;

    // Tag row memory, one row per set
    tags_t  tag_mem   [ROWS];
    valid_t valid_mem [ROWS];
    lru_t   lru_mem   [ROWS];

    tags_t  rd_tags_reg;
    valid_t rd_valid_reg;
    lru_t   rd_lru_reg;

    logic [1:0]          state_reg, state_next;
    logic [SET_AW-1:0]   clr_reg;
    item_t               item_reg;
    logic [ADDR_W-1:0]   mshr_reg [MSHR_DEPTH];
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    keep_reg;
    logic [MSHR_DEPTH-1:0] mask_reg;
    logic                any_rel_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic                out_last_reg;

    logic                out_free;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
    logic [ADDR_W-1:0]   emit_addr;
    logic                emit_last;

    logic                rd_en;
    logic [SET_AW-1:0]   rd_addr;
    logic                wr_en;
    logic [SET_AW-1:0]   wr_addr;
    tags_t               wr_tags;
    valid_t              wr_valid;
    lru_t                wr_lru;
    lru_t                reset_lru;

    logic [SET_AW-1:0]   cur_set;
    logic [TAG_W-1:0]    cur_tag;
    logic                hit;
    logic [WAY_W-1:0]    hit_pos;
    lru_t                hit_lru;
    lru_t                fill_lru;
    logic [WAY_W-1:0]    victim;
    logic [MSHR_DEPTH-1:0] line_match;
    logic                dup;
    logic                full;
    logic [ADDR_W-1:0]   rel_entry;
    logic [MSHR_DEPTH-1:0] rel_rest;

    logic do_insert;
    logic do_keep;
    logic do_fill_done;
    logic do_rel_step;
    logic do_look_fill;

    // Move the way at LRU position pos to the MRU end
    function automatic lru_t mru_move(input lru_t l, input logic [WAY_W-1:0] pos);
        lru_t r;
        r = l;
        for (int i = 0; i < WAYS - 1; i++)
        begin
            if (WAY_W'(i) >= pos)
            begin
                r[i] = l[(i + 1 < WAYS) ? i + 1 : i];
            end
        end
        r[WAYS-1] = l[pos];
        return r;
    endfunction

    function automatic logic [SET_AW-1:0] set_of(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] s;
        s = (a >> OFF) & SMASK;
        return s[SET_AW-1:0];
    endfunction

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            reset_lru[i] = WAY_W'(i);
        end
    end

    assign cur_set  = set_of(item_reg.addr);
    assign cur_tag  = TAG_W'(item_reg.addr >> (OFF + IDX));
    assign out_free = !out_valid_reg || m_tready;
    assign full     = (cnt_reg == CNT_W'(MSHR_DEPTH));
    assign victim   = rd_lru_reg[0];

    // Search the set from LRU to MRU; the last match is nearest MRU
    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int p = 0; p < WAYS; p++)
        begin
            if (rd_valid_reg[rd_lru_reg[p]] && rd_tags_reg[rd_lru_reg[p]] == cur_tag)
            begin
                hit     = 1'b1;
                hit_pos = WAY_W'(p);
            end
        end
    end

    assign hit_lru  = mru_move(rd_lru_reg, hit_pos);
    assign fill_lru = mru_move(rd_lru_reg, '0);

    // Compare every waiting entry with the current line
    always_comb
    begin
        for (int i = 0; i < MSHR_DEPTH; i++)
        begin
            line_match[i] = (CNT_W'(i) < cnt_reg) &&
                            ((mshr_reg[i] >> OFF) == (item_reg.addr >> OFF));
        end
    end

    assign dup       = |line_match;
    assign rel_entry = mshr_reg[idx_reg[MI_W-1:0]];
    assign rel_rest  = mask_reg & ~(MSHR_DEPTH'(1) << idx_reg[MI_W-1:0]);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        pop          = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = set_of(head.item.addr);
        wr_en        = 1'b0;
        wr_addr      = cur_set;
        wr_tags      = rd_tags_reg;
        wr_valid     = rd_valid_reg;
        wr_lru       = hit_lru;
        emit         = 1'b0;
        emit_status  = ST_HIT;
        emit_addr    = item_reg.addr;
        emit_last    = 1'b1;
        do_insert    = 1'b0;
        do_keep      = 1'b0;
        do_fill_done = 1'b0;
        do_rel_step  = 1'b0;
        do_look_fill = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_tags  = '0;
                wr_valid = '0;
                wr_lru   = reset_lru;
                if (clr_reg == SET_AW'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    rd_en      = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (item_reg.is_fill)
                begin
                    do_look_fill = 1'b1;
                    state_next   = S_REL;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (hit)
                    begin
                        emit_status = ST_HIT;
                        wr_en       = 1'b1;
                    end
                    else if (item_reg.is_store)
                    begin
                        emit_status = ST_MISS;
                    end
                    else if (full)
                    begin
                        emit_status = ST_FULL;
                    end
                    else
                    begin
                        emit_status = dup ? ST_MISS_DUP : ST_MISS;
                        do_insert   = 1'b1;
                    end
                end
            end
            S_REL:
            begin
                if (idx_reg == cnt_reg)
                begin
                    if (out_free || any_rel_reg)
                    begin
                        emit         = !any_rel_reg;
                        emit_status  = ST_FILL_EMPTY;
                        do_fill_done = 1'b1;
                        wr_en        = 1'b1;
                        wr_tags[victim]  = cur_tag;
                        wr_valid[victim] = 1'b1;
                        wr_lru       = fill_lru;
                        state_next   = S_IDLE;
                    end
                end
                else if (mask_reg[idx_reg[MI_W-1:0]])
                begin
                    if (out_free)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_RELEASED;
                        emit_addr   = rel_entry;
                        emit_last   = (rel_rest == '0);
                        do_rel_step = 1'b1;
                    end
                end
                else
                begin
                    do_keep = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Tag row memory ports
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_tags_reg  <= tag_mem[rd_addr];
            rd_valid_reg <= valid_mem[rd_addr];
            rd_lru_reg   <= lru_mem[rd_addr];
        end
        if (wr_en)
        begin
            tag_mem[wr_addr]   <= wr_tags;
            valid_mem[wr_addr] <= wr_valid;
            lru_mem[wr_addr]   <= wr_lru;
        end
    end

    // Miss buffer entries: shift in on load miss, compact during release
    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            for (int i = MSHR_DEPTH - 1; i > 0; i--)
            begin
                mshr_reg[i] <= mshr_reg[i-1];
            end
            mshr_reg[0] <= item_reg.addr;
        end
        else if (do_keep)
        begin
            mshr_reg[keep_reg[MI_W-1:0]] <= rel_entry;
        end
    end

    // Hold the current word and the result word
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head.item;
        end
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_addr_reg   <= emit_addr;
            out_last_reg   <= emit_last;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            keep_reg      <= '0;
            mask_reg      <= '0;
            any_rel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + SET_AW'(1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (do_insert)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (do_look_fill)
            begin
                idx_reg     <= '0;
                keep_reg    <= '0;
                mask_reg    <= line_match;
                any_rel_reg <= 1'b0;
            end
            if (do_keep)
            begin
                idx_reg  <= idx_reg + CNT_W'(1);
                keep_reg <= keep_reg + CNT_W'(1);
            end
            if (do_rel_step)
            begin
                idx_reg     <= idx_reg + CNT_W'(1);
                mask_reg    <= rel_rest;
                any_rel_reg <= 1'b1;
            end
            if (do_fill_done)
            begin
                cnt_reg <= keep_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/set_assoc_lru_cache_tags_with_mshr_unit.sv =====
// Set-associative tag store with true LRU replacement and a miss buffer.
// For a lookup the back end pops the queue and reads the set's tag row, then,
// with the output register free, resolves hit or miss and updates the row on
// a hit. For a fill the release sequencer then steps through the miss buffer
// one entry per cycle, a released entry waiting for a free output register,
// and writes the replaced way. After reset a clearing pass walks all the tag
// memory's 2**floor(log2(SET_COUNT)) sets, 64 by default, one set per cycle,
// before the first word leaves the input queue. Input words go into a two-entry
// queue while the back end works, and results leave through an output register.
module set_assoc_lru_cache_tags_with_mshr_unit
    import sal_pkg::*;
#(
    parameter int WAYS       = DEF_WAYS,
    parameter int SET_COUNT  = DEF_SET_COUNT,
    parameter int LINE_BYTES = DEF_LINE_BYTES,
    parameter int MSHR_DEPTH = DEF_MSHR_DEPTH,
    parameter int ADDR_BITS  = DEF_ADDR_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ADDR_W-1:0]   s_tdata,   // addr
    input  logic [1:0]          s_tuser,   // action, is_store
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [ADDR_W-1:0]   m_tdata,   // waiter_addr
    output logic [STATUS_W-1:0] m_tuser,   // status
    output logic                m_tlast
);

    queue_head_t head;
    logic        pop;

    sal_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    sal_back #(
        .WAYS       (WAYS),
        .SET_COUNT  (SET_COUNT),
        .LINE_BYTES (LINE_BYTES),
        .MSHR_DEPTH (MSHR_DEPTH),
        .ADDR_BITS  (ADDR_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/core/sal_checker.sv =====
// Port-level checks for the tag store unit, attached by bind.
// Depends on sal_pkg and the top level's ports.
module sal_checker
    import sal_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [ADDR_W-1:0]   s_tdata,
    input logic [1:0]          s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [ADDR_W-1:0]   m_tdata,
    input logic [STATUS_W-1:0] m_tuser,
    input logic                m_tlast
);

    // Offered request word and input ready are known
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> !$isunknown({s_tready, s_tdata, s_tuser}))
        else $error("offered request word unknown");

    // Stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // Only defined status codes leave
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_HIT || m_tuser == ST_MISS ||
                      m_tuser == ST_MISS_DUP || m_tuser == ST_FULL ||
                      m_tuser == ST_RELEASED || m_tuser == ST_FILL_EMPTY))
        else $error("undefined status code");

    // Everything but a released waiter is a single, final word
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_RELEASED |-> m_tlast)
        else $error("single result without last");

    // A released waiter without last is followed by another released waiter
    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser == ST_RELEASED && !m_tlast
        |=> !m_tvalid || m_tuser == ST_RELEASED)
        else $error("release run broken");

endmodule

bind set_assoc_lru_cache_tags_with_mshr_unit sal_checker u_sal_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
